@@ sv/envelope_noise_gate_defines.svh @@
// Assertion macros for the envelope noise gate.
`ifndef ENVELOPE_NOISE_GATE_DEFINES_SVH
`define ENVELOPE_NOISE_GATE_DEFINES_SVH
`ifndef SYNTH
`define EG_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("envelope noise gate check failed");
`define EG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("envelope noise gate sequence check failed");
`else
`define EG_ASSERT(lbl, ante, cons)
`define EG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/engate_pkg.sv @@
`timescale 1ns / 1ps
package engate_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int SAMPLE_W   = 24;
  localparam int ENV_W      = 24;
  localparam int COEF_W     = 16;
  localparam int THR_W      = 24;
  localparam int DIFF_W     = ENV_W + 1;
  localparam int PROD_W     = DIFF_W + COEF_W + 1;
  localparam int STEP_W     = PROD_W - COEF_W;
  localparam int ENV_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int ENV_MAX    = 1 << (SAMPLE_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd2;

  localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd1350;
  localparam logic [COEF_W-1:0] RELEASE_RST = 16'd68;
  localparam logic [THR_W-1:0]  THRESH_RST  = 24'd4715;

  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       gate_open;
  } out_t;

  typedef struct packed {
    logic [COEF_W-1:0] attack_coef;
    logic [COEF_W-1:0] release_coef;
    logic [THR_W-1:0]  open_threshold;
  } cfg_t;

endpackage

@@ sv/engate_ram.sv @@
`timescale 1ns / 1ps
module engate_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 24,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/engate_core.sv @@
`timescale 1ns / 1ps
`include "envelope_noise_gate_defines.svh"
module engate_core
  import engate_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic sample_valid,
  output logic sample_ready,
  input  in_t  sample_item,
  input  logic out_free,
  output logic res_load,
  output out_t res
);

  logic              acc;
  logic              s1_move;
  logic              s2_move;
  logic [ENV_AW-1:0] rd_addr;
  logic [ENV_W-1:0]  rd_data;
  logic              rd_ok;
  logic              in_ok;

  logic                       s1_valid;
  logic                       s1_ok;
  logic [CH_W-1:0]            s1_ch;
  logic signed [SAMPLE_W-1:0] s1_sample;

  logic                       s2_valid;
  logic                       s2_ok;
  logic [CH_W-1:0]            s2_ch;
  logic signed [SAMPLE_W-1:0] s2_sample;
  logic [ENV_W-1:0]           s2_env;
  logic signed [PROD_W-1:0]   s2_prod;

  logic                       lw_valid;
  logic [CH_W-1:0]            lw_ch;
  logic [ENV_W-1:0]           lw_env;

  logic [CHANNELS-1:0]        ent_valid;
  logic                       mem_we;
  logic [ENV_AW-1:0]          wr_addr;

  logic [ENV_W-1:0]           env_cur;
  logic [ENV_W-1:0]           mag;
  logic                       rise;
  logic [COEF_W-1:0]          coef;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [STEP_W-1:0]   env_sum;
  logic [ENV_W-1:0]           env_new;
  logic                       open;

  assign s2_move      = !s2_valid || out_free;
  assign s1_move      = !s1_valid || s2_move;
  assign sample_ready = s1_move;
  assign acc          = sample_valid && sample_ready;
  assign rd_addr      = ENV_AW'(sample_item.channel);
  assign in_ok        = (int'(sample_item.channel) < CHANNELS);

  engate_ram #(
    .DEPTH (CHANNELS),
    .WIDTH (ENV_W)
  ) u_env_ram (
    .clk   (clk),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (rd_data),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (env_new)
  );

  // forward the newest envelope of the channel
  always_comb begin
    if (s2_valid && s2_ok && s2_ch == s1_ch) begin
      env_cur = env_new;
    end else if (lw_valid && lw_ch == s1_ch) begin
      env_cur = lw_env;
    end else if (rd_ok) begin
      env_cur = rd_data;
    end else begin
      env_cur = '0;
    end
  end

  always_comb begin
    mag  = s1_sample[SAMPLE_W-1] ? ENV_W'(-s1_sample) : ENV_W'(s1_sample);
    rise = mag > env_cur;
    coef = rise ? cfg.attack_coef : cfg.release_coef;
    diff = $signed({1'b0, mag}) - $signed({1'b0, env_cur});
    prod = diff * $signed({1'b0, coef});
  end

  always_comb begin
    env_sum = $signed({{(STEP_W-ENV_W){1'b0}}, s2_env}) + s2_prod[PROD_W-1:COEF_W];
    env_new = env_sum[ENV_W-1:0];
    open    = s2_ok && (env_new > cfg.open_threshold);
  end

  assign res_load = s2_valid && out_free;
  assign mem_we   = res_load && s2_ok;
  assign wr_addr  = ENV_AW'(s2_ch);

  always_comb begin
    res.out_channel = s2_ch;
    res.sample_out  = open ? s2_sample : '0;
    res.gate_open   = open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      lw_valid  <= 1'b0;
      ent_valid <= '0;
    end else begin
      if (s1_move) begin
        s1_valid <= acc;
      end
      if (s2_move) begin
        s2_valid <= s1_valid;
      end
      if (mem_we) begin
        lw_valid           <= 1'b1;
        ent_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ch     <= sample_item.channel;
      s1_sample <= sample_item.sample_in;
      s1_ok     <= in_ok;
      rd_ok     <= ent_valid[rd_addr];
    end
    if (s2_move && s1_valid) begin
      s2_ch     <= s1_ch;
      s2_sample <= s1_sample;
      s2_ok     <= s1_ok;
      s2_env    <= env_cur;
      s2_prod   <= prod;
    end
    if (mem_we) begin
      lw_ch  <= s2_ch;
      lw_env <= env_new;
    end
  end

  `EG_ASSERT(a_env_bound, s2_valid && s2_ok, env_sum >= 0 && env_sum <= ENV_MAX)
  `EG_ASSERT(a_open_nonzero, s2_valid && open, env_new != '0 && s2_ok)
  `EG_ASSERT_NEXT(a_we_marks_entry, mem_we, ent_valid[$past(wr_addr)] && lw_valid)
  `EG_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_move, s1_valid && $stable(s1_ch))
  `EG_ASSERT(a_no_write_on_stall, s2_valid && !out_free, !mem_we)

endmodule

@@ sv/envelope_noise_gate.sv @@
`timescale 1ns / 1ps
// Two-channel noise gate with a one-pole envelope follower per channel. One sample transfer is
// accepted every cycle unless a held result stalls the pipeline, also back to back on the same
// channel; a result passes through the s1 and s2 stages and is held in an output register until
// taken. The envelopes live in a small one-port-read, one-port-write RAM that is read at accept
// and written back when the result is loaded into the output register; the newest envelope is
// forwarded around the RAM, so the clock period is set by the multiply, add and compare loop of
// the follower. Envelopes start at zero after reset through per-entry valid bits, with no
// clearing pass. Write coefficients and the threshold only while no transfer is in flight.
module envelope_noise_gate
  import engate_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  in_t                   sample_item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output out_t                  result_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic out_free;
  logic res_load;
  out_t res;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_coef    <= ATTACK_RST;
      cfg.release_coef   <= RELEASE_RST;
      cfg.open_threshold <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:  cfg.attack_coef    <= cfg_data[COEF_W-1:0];
        REG_RELEASE: cfg.release_coef   <= cfg_data[COEF_W-1:0];
        REG_THRESH:  cfg.open_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  engate_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result_item <= res;
    end
  end

endmodule
